@@ hdl/cvba_pkg.sv @@
// shared types and constants for the calibrated voltage block averager
package cvba_pkg;

  localparam int DATA_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int AVG_LOG2_W = 4;
  localparam int BLANK_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CH_MAX = 3;
  localparam int CH_IDX_W   = 2;

  localparam int DEF_CHANNELS     = 3;
  localparam int DEF_BLANK_ITEMS  = 60;
  localparam int DEF_MAX_AVG_LOG2 = 10;
  localparam int DEF_MIN_START    = 0;
  localparam int DEF_MAX_START    = 39321600;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_CLR_MIN = 2'd1,
    OP_CLR_MAX = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] supply_scale;
  } in_item_t;

  typedef struct packed {
    logic [NUM_CH_MAX-1:0]    new_mask;
    logic signed [DATA_W-1:0] inst_0;
    logic signed [DATA_W-1:0] inst_1;
    logic signed [DATA_W-1:0] inst_2;
    logic signed [DATA_W-1:0] max_0;
    logic signed [DATA_W-1:0] max_1;
    logic signed [DATA_W-1:0] max_2;
    logic signed [DATA_W-1:0] min_0;
    logic signed [DATA_W-1:0] min_1;
    logic signed [DATA_W-1:0] min_2;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                blank_dec;
    logic                clear_min;
    logic                clear_max;
    logic                mask_clr;
    logic                load_prod;
    logic                load_full;
    logic                load_f;
    logic                acc_en;
    logic                avg_en;
    logic                zero_en;
    logic                out_load;
    logic [CH_IDX_W-1:0] ch;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       blank_zero;
    logic       single_mode;
  } status_t;

endpackage

@@ hdl/cvba_ctrl.sv @@
// sequencing state machine: dispatches an item and walks the channels
module cvba_ctrl #(
  parameter int Channels = cvba_pkg::DEF_CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cvba_pkg::status_t status_i,
  output cvba_pkg::cmd_t    cmd_o
);
  import cvba_pkg::*;

  localparam int NumCh = (Channels < NUM_CH_MAX) ? Channels : NUM_CH_MAX;
  localparam logic [CH_IDX_W-1:0] LastCh = CH_IDX_W'(NumCh - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_GAIN,
    ST_CAL,
    ST_ACC,
    ST_AVG,
    ST_ZERO,
    ST_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.mask_clr = 1'b1;
        ch_d           = '0;
        priority if (status_i.op == OP_PUSH) begin
          if (!status_i.blank_zero) begin
            cmd_o.blank_dec = 1'b1;
            state_d         = ST_OUT;
          end else begin
            state_d = ST_MUL;
          end
        end else if (status_i.op == OP_CLR_MIN) begin
          cmd_o.clear_min = 1'b1;
          state_d         = ST_OUT;
        end else if (status_i.op == OP_CLR_MAX) begin
          cmd_o.clear_max = 1'b1;
          state_d         = ST_OUT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d         = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.load_full = 1'b1;
        state_d         = ST_CAL;
      end
      ST_CAL: begin
        cmd_o.load_f = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_AVG;
      end
      ST_AVG, ST_ZERO: begin
        cmd_o.avg_en  = (state_q == ST_AVG);
        cmd_o.zero_en = (state_q == ST_ZERO);
        if (ch_q == LastCh) begin
          state_d = ST_OUT;
        end else begin
          // channels above 0 are forced to zero in two-wire mode
          ch_d    = ch_q + CH_IDX_W'(1);
          state_d = status_i.single_mode ? ST_ZERO : ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/cvba_dpath.sv @@
// datapath: config registers, calibration multiplies, accumulators, min/max
module cvba_dpath #(
  parameter int Channels   = cvba_pkg::DEF_CHANNELS,
  parameter int BlankItems = cvba_pkg::DEF_BLANK_ITEMS,
  parameter int MaxAvgLog2 = cvba_pkg::DEF_MAX_AVG_LOG2,
  parameter int MinStart   = cvba_pkg::DEF_MIN_START,
  parameter int MaxStart   = cvba_pkg::DEF_MAX_START
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cvba_pkg::in_item_t             in_item_i,
  input  logic                           cfg_valid_i,
  input  logic [cvba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cvba_pkg::DATA_W-1:0]    cfg_data_i,
  input  cvba_pkg::cmd_t                 cmd_i,
  output cvba_pkg::status_t              status_o,
  output cvba_pkg::out_item_t            out_item_o
);
  import cvba_pkg::*;

  localparam int NumCh = (Channels < NUM_CH_MAX) ? Channels : NUM_CH_MAX;
  localparam int AccW  = DATA_W + MaxAvgLog2 + 1;
  localparam int CntW  = MaxAvgLog2 + 1;
  localparam int ProdW = 2 * SAMPLE_W;
  localparam int FullW = 2 * DATA_W;
  localparam int FracShift = 14;
  localparam logic [NUM_CH_MAX-1:0] PresMask = NUM_CH_MAX'((1 << NumCh) - 1);
  localparam logic signed [DATA_W-1:0] MinStartV = DATA_W'(MinStart);
  localparam logic signed [DATA_W-1:0] MaxStartV = DATA_W'(MaxStart);
  localparam logic signed [DATA_W-1:0] SatHi = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SatLo = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_LOG2 = 3'd0,
    CFG_SINGLE   = 3'd1,
    CFG_GAIN_0   = 3'd2,
    CFG_GAIN_1   = 3'd3,
    CFG_GAIN_2   = 3'd4,
    CFG_OFFSET_0 = 3'd5,
    CFG_OFFSET_1 = 3'd6,
    CFG_OFFSET_2 = 3'd7
  } cfg_idx_e;

  localparam int HiW = FullW - FracShift;

  function automatic logic signed [DATA_W-1:0] sat_hi(input logic signed [HiW-1:0] v);
    logic [HiW-DATA_W:0] top;
    top = v[HiW-1:DATA_W-1];
    if (top == {(HiW-DATA_W+1){v[HiW-1]}}) return v[DATA_W-1:0];
    return v[HiW-1] ? SatLo : SatHi;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
    if (v[DATA_W] == v[DATA_W-1]) return v[DATA_W-1:0];
    return v[DATA_W] ? SatLo : SatHi;
  endfunction

  // config
  logic [AVG_LOG2_W-1:0]    avg_log2_q;
  logic                     single_q;
  logic signed [DATA_W-1:0] gain_q   [NUM_CH_MAX];
  logic signed [DATA_W-1:0] offset_q [NUM_CH_MAX];
  logic                     avg_wr;

  assign avg_wr = cfg_valid_i && (cfg_idx_e'(cfg_index_i) == CFG_AVG_LOG2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_log2_q <= '0;
      single_q   <= 1'b0;
      for (int i = 0; i < NUM_CH_MAX; i++) begin
        gain_q[i]   <= DATA_W'(65536);
        offset_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AVG_LOG2: avg_log2_q  <= cfg_data_i[AVG_LOG2_W-1:0];
        CFG_SINGLE:   single_q    <= cfg_data_i[0];
        CFG_GAIN_0:   gain_q[0]   <= cfg_data_i;
        CFG_GAIN_1:   gain_q[1]   <= cfg_data_i;
        CFG_GAIN_2:   gain_q[2]   <= cfg_data_i;
        CFG_OFFSET_0: offset_q[0] <= cfg_data_i;
        CFG_OFFSET_1: offset_q[1] <= cfg_data_i;
        CFG_OFFSET_2: offset_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture and blanking
  in_item_t           item_q;
  logic [BLANK_W-1:0] blank_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BLANK_W'(BlankItems);
    end else if (cmd_i.blank_dec) begin
      blank_q <= blank_q - BLANK_W'(1);
    end
  end

  assign status_o.op          = item_q.operation;
  assign status_o.blank_zero  = (blank_q == '0);
  assign status_o.single_mode = single_q;

  // calibration chain, one channel at a time
  logic [SAMPLE_W-1:0]       sample_sel;
  logic [ProdW-1:0]          prod_q;
  logic signed [FullW:0]     full_w;
  logic signed [FullW-1:0]   full_q;
  logic signed [DATA_W-1:0]  cal_f1;
  logic signed [DATA_W:0]    cal_sum;
  logic signed [DATA_W-1:0]  f_q;

  always_comb begin
    unique case (cmd_i.ch)
      CH_IDX_W'(1): sample_sel = item_q.sample_1;
      CH_IDX_W'(2): sample_sel = item_q.sample_2;
      default:      sample_sel = item_q.sample_0;
    endcase
  end

  assign full_w  = $signed(gain_q[cmd_i.ch]) * $signed({1'b0, prod_q});
  assign cal_f1  = sat_hi(full_q[FullW-1:FracShift]);
  assign cal_sum = {cal_f1[DATA_W-1], cal_f1}
                 + {offset_q[cmd_i.ch][DATA_W-1], offset_q[cmd_i.ch]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) prod_q <= ProdW'(sample_sel) * ProdW'(item_q.supply_scale);
    if (cmd_i.load_full) full_q <= full_w[FullW-1:0];
    if (cmd_i.load_f)    f_q    <= sat_sum(cal_sum);
  end

  // accumulate and average
  logic signed [AccW-1:0]   acc_q  [NUM_CH_MAX];
  logic [CntW-1:0]          cnt_q  [NUM_CH_MAX];
  logic signed [DATA_W-1:0] inst_q [NUM_CH_MAX];
  logic signed [DATA_W-1:0] max_q  [NUM_CH_MAX];
  logic signed [DATA_W-1:0] min_q  [NUM_CH_MAX];
  logic [NUM_CH_MAX-1:0]    mask_q;
  logic [AVG_LOG2_W-1:0]    k_eff;
  logic [CntW-1:0]          target;
  logic signed [AccW-1:0]   acc_shift;
  logic signed [DATA_W-1:0] mean;
  logic                     avg_done;

  assign k_eff     = (avg_log2_q > AVG_LOG2_W'(MaxAvgLog2)) ? '0 : avg_log2_q;
  assign target    = CntW'(1) << k_eff;
  assign acc_shift = acc_q[cmd_i.ch] >>> k_eff;
  assign mean      = acc_shift[DATA_W-1:0];
  assign avg_done  = cmd_i.avg_en && (cnt_q[cmd_i.ch] >= target);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH_MAX; i++) begin
        acc_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (avg_wr) begin
      for (int i = 0; i < NUM_CH_MAX; i++) begin
        acc_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      acc_q[cmd_i.ch] <= acc_q[cmd_i.ch] + AccW'(f_q);
      cnt_q[cmd_i.ch] <= cnt_q[cmd_i.ch] + CntW'(1);
    end else if (avg_done) begin
      acc_q[cmd_i.ch] <= '0;
      cnt_q[cmd_i.ch] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int i = 0; i < NUM_CH_MAX; i++) begin
        inst_q[i] <= '0;
        max_q[i]  <= MinStartV;
        min_q[i]  <= MaxStartV;
      end
    end else begin
      if (cmd_i.mask_clr) mask_q <= '0;
      if (cmd_i.clear_min) begin
        for (int i = 0; i < NUM_CH_MAX; i++) min_q[i] <= MaxStartV;
      end
      if (cmd_i.clear_max) begin
        for (int i = 0; i < NUM_CH_MAX; i++) max_q[i] <= MinStartV;
      end
      if (avg_done) begin
        inst_q[cmd_i.ch] <= mean;
        if (mean > max_q[cmd_i.ch]) max_q[cmd_i.ch] <= mean;
        if (mean < min_q[cmd_i.ch]) min_q[cmd_i.ch] <= mean;
        mask_q[cmd_i.ch] <= 1'b1;
      end
      if (cmd_i.zero_en) begin
        inst_q[cmd_i.ch] <= '0;
        max_q[cmd_i.ch]  <= '0;
        min_q[cmd_i.ch]  <= '0;
      end
    end
  end

  // output register, absent channels read zero
  out_item_t out_d;
  out_item_t out_q;

  always_comb begin
    out_d.new_mask = mask_q & PresMask;
    out_d.inst_0   = PresMask[0] ? inst_q[0] : '0;
    out_d.inst_1   = PresMask[1] ? inst_q[1] : '0;
    out_d.inst_2   = PresMask[2] ? inst_q[2] : '0;
    out_d.max_0    = PresMask[0] ? max_q[0]  : '0;
    out_d.max_1    = PresMask[1] ? max_q[1]  : '0;
    out_d.max_2    = PresMask[2] ? max_q[2]  : '0;
    out_d.min_0    = PresMask[0] ? min_q[0]  : '0;
    out_d.min_1    = PresMask[1] ? min_q[1]  : '0;
    out_d.min_2    = PresMask[2] ? min_q[2]  : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_item_o = out_q;

endmodule

@@ hdl/calibrated_voltage_block_averager_unit.sv @@
// top level of the calibrated voltage block averager with min/max tracking
//
//  channel  | direction | handshake                | beat
//  ---------+-----------+--------------------------+----------------------------
//  in       | in        | in_valid_i / in_ready_o  | in_item_i: op, 3 samples, scale
//  out      | out       | out_valid_o / out_ready_i| out_item_o: mask, inst/max/min
//  cfg      | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one item at a time; a push after blanking walks each built channel in turn
// through the shared multiply/calibrate chain (product, gain, saturate+offset,
// add, average) before the next beat is taken; in two-wire mode channels 1
// and 2 are only zeroed; blanked pushes, clear operations and the unused code
// go from dispatch straight to the output step
// the result sits in an output register; the next beat is taken while it waits,
// and a finished item waits in the last step only if that register is still full
// reset reloads the blanking count and resets accumulators, min/max and config; no clearing pass
module calibrated_voltage_block_averager_unit #(
  parameter int Channels   = cvba_pkg::DEF_CHANNELS,
  parameter int BlankItems = cvba_pkg::DEF_BLANK_ITEMS,
  parameter int MaxAvgLog2 = cvba_pkg::DEF_MAX_AVG_LOG2,
  parameter int MinStart   = cvba_pkg::DEF_MIN_START,
  parameter int MaxStart   = cvba_pkg::DEF_MAX_START
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cvba_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cvba_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cvba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cvba_pkg::DATA_W-1:0]    cfg_data_i
);
  import cvba_pkg::*;

  localparam int NumCh = (Channels < NUM_CH_MAX) ? Channels : NUM_CH_MAX;
  localparam logic [NUM_CH_MAX-1:0] AbsentMask = ~NUM_CH_MAX'((1 << NumCh) - 1);

  cmd_t    cmd;
  status_t status;

  // config writes land directly in registers, so always ready
  assign cfg_ready_o = 1'b1;

  // sequencer: dispatch on operation, then one channel after another
  cvba_ctrl #(
    .Channels (Channels)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // calibration, accumulation, min/max and output register
  cvba_dpath #(
    .Channels   (Channels),
    .BlankItems (BlankItems),
    .MaxAvgLog2 (MaxAvgLog2),
    .MinStart   (MinStart),
    .MaxStart   (MaxStart)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

  // one item in flight: after a beat is taken, input closes
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a result only appears after an item was worked on
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a busy cycle");

  // absent channels never flag a new average
  a_absent_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.new_mask & AbsentMask) == '0))
    else $error("mask bit set for an absent channel");

endmodule
